// ===== rtl/core/ihex_pkg.sv =====
`default_nettype none
package ihex_pkg;

  localparam int unsigned RES_DEPTH_DEF = 4;

  localparam logic [31:0] CAPACITY_RST = 32'd65536;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_SEG  = 8'h02;
  localparam logic [7:0] REC_LIN  = 8'h04;

  localparam logic [1:0] FLD_COUNT  = 2'd0;
  localparam logic [1:0] FLD_OFS_HI = 2'd1;
  localparam logic [1:0] FLD_OFS_LO = 2'd2;
  localparam logic [1:0] FLD_TYPE   = 2'd3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_SKIP     = 3'd1,
    PH_HEADER   = 3'd2,
    PH_DATA     = 3'd3,
    PH_EXT      = 3'd4,
    PH_FINISHED = 3'd5
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [31:0] length;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_push_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ihex_parser.sv =====
`default_nettype none
module ihex_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         char_in,
  input  wire logic               end_of_input,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  output ihex_pkg::res_push_t     push
);
  import ihex_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        nib_held_r, nib_held_nxt;
  logic [3:0]  nib_val_r, nib_val_nxt;
  logic [1:0]  fidx_r, fidx_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] ofs_r, ofs_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  didx_r, didx_nxt;
  logic [7:0]  ext_r, ext_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] high_r, high_nxt;
  logic [31:0] cur_addr_r, cur_addr_nxt;
  logic [31:0] cap_r;

  logic [4:0]  dig;
  logic [7:0]  byte_v;
  logic [31:0] addr_p1;
  logic [15:0] v16;
  logic        blank;
  logic        tk_vld;
  res_t        tk_res;
  logic        eoi_vld;
  res_t        eoi_res;

  assign blank = (char_in == CHAR_SPACE) || (char_in inside {[8'h09:8'h0D]});
  assign dig = hex_digit(char_in);
  assign byte_v = {nib_val_r, dig[3:0]};
  assign addr_p1 = cur_addr_r + 32'd1;

  always_comb begin
    phase_nxt    = phase_r;
    nib_held_nxt = nib_held_r;
    nib_val_nxt  = nib_val_r;
    fidx_nxt     = fidx_r;
    count_nxt    = count_r;
    ofs_nxt      = ofs_r;
    kind_nxt     = kind_r;
    didx_nxt     = didx_r;
    ext_nxt      = ext_r;
    base_nxt     = base_r;
    high_nxt     = high_r;
    cur_addr_nxt = cur_addr_r;
    tk_vld       = 1'b0;
    tk_res       = '0;
    eoi_vld      = 1'b0;
    eoi_res      = '0;
    v16          = {ext_r, byte_v};

    if (phase_r == PH_FINISHED) begin
      phase_nxt = PH_FINISHED;
    end else if (char_in == CHAR_LF) begin
      phase_nxt    = PH_START;
      nib_held_nxt = 1'b0;
      nib_val_nxt  = 4'd0;
    end else if (phase_r == PH_START) begin
      if (!blank) begin
        if (char_in == CHAR_COLON) begin
          phase_nxt    = PH_HEADER;
          fidx_nxt     = FLD_COUNT;
          nib_held_nxt = 1'b0;
          nib_val_nxt  = 4'd0;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
    end else if (phase_r == PH_HEADER || phase_r == PH_DATA || phase_r == PH_EXT) begin
      if (dig[4]) begin
        phase_nxt    = PH_SKIP;
        nib_held_nxt = 1'b0;
        nib_val_nxt  = 4'd0;
      end else if (!nib_held_r) begin
        nib_held_nxt = 1'b1;
        nib_val_nxt  = dig[3:0];
      end else begin
        nib_held_nxt = 1'b0;
        nib_val_nxt  = 4'd0;
        case (phase_r)
          PH_HEADER: begin
            case (fidx_r)
              FLD_COUNT:  count_nxt = byte_v;
              FLD_OFS_HI: ofs_nxt = {byte_v, 8'h00};
              FLD_OFS_LO: ofs_nxt = {ofs_r[15:8], byte_v};
              default:    kind_nxt = byte_v;
            endcase
            if (fidx_r == FLD_TYPE) begin
              case (byte_v)
                REC_DATA: begin
                  didx_nxt     = 8'd0;
                  cur_addr_nxt = base_r + {16'h0000, ofs_r};
                  phase_nxt    = (count_r == 8'd0) ? PH_SKIP : PH_DATA;
                end
                REC_EOF: begin
                  tk_vld         = 1'b1;
                  tk_res.kind    = KIND_DONE;
                  tk_res.length  = high_r;
                  nib_held_nxt   = 1'b0;
                  nib_val_nxt    = 4'd0;
                  fidx_nxt       = 2'd0;
                  count_nxt      = 8'd0;
                  ofs_nxt        = 16'd0;
                  kind_nxt       = 8'd0;
                  didx_nxt       = 8'd0;
                  ext_nxt        = 8'd0;
                  base_nxt       = 32'd0;
                  high_nxt       = 32'd0;
                  cur_addr_nxt   = 32'd0;
                  phase_nxt      = PH_FINISHED;
                end
                REC_SEG, REC_LIN: begin
                  fidx_nxt  = 2'd0;
                  phase_nxt = PH_EXT;
                end
                default: phase_nxt = PH_SKIP;
              endcase
            end else begin
              fidx_nxt = fidx_r + 2'd1;
            end
          end
          PH_DATA: begin
            if (cur_addr_r < cap_r) begin
              tk_vld            = 1'b1;
              tk_res.kind       = KIND_WRITE;
              tk_res.address    = cur_addr_r;
              tk_res.data_byte  = byte_v;
            end
            if (addr_p1 > high_r) begin
              high_nxt = addr_p1;
            end
            cur_addr_nxt = addr_p1;
            didx_nxt     = didx_r + 8'd1;
            if (didx_r + 8'd1 == count_r) begin
              phase_nxt = PH_SKIP;
            end
          end
          default: begin
            if (fidx_r == 2'd0) begin
              ext_nxt  = byte_v;
              fidx_nxt = 2'd1;
            end else begin
              base_nxt  = (kind_r == REC_SEG) ? {12'h000, v16, 4'h0} : {v16, 16'h0000};
              phase_nxt = PH_SKIP;
            end
          end
        endcase
      end
    end else begin
      phase_nxt = (phase_r == PH_SKIP) ? PH_SKIP : PH_START;
    end

    if (end_of_input) begin
      if (phase_nxt != PH_FINISHED) begin
        eoi_vld        = 1'b1;
        eoi_res.kind   = KIND_DONE;
        eoi_res.length = high_nxt;
      end
      nib_held_nxt = 1'b0;
      nib_val_nxt  = 4'd0;
      fidx_nxt     = 2'd0;
      count_nxt    = 8'd0;
      ofs_nxt      = 16'd0;
      kind_nxt     = 8'd0;
      didx_nxt     = 8'd0;
      ext_nxt      = 8'd0;
      base_nxt     = 32'd0;
      high_nxt     = 32'd0;
      cur_addr_nxt = 32'd0;
      phase_nxt    = PH_START;
    end
  end

  always_comb begin
    push = '0;
    if (step) begin
      push.n  = {1'b0, tk_vld} + {1'b0, eoi_vld};
      push.r0 = tk_vld ? tk_res : eoi_res;
      push.r1 = eoi_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      nib_held_r <= 1'b0;
      nib_val_r  <= 4'd0;
      fidx_r     <= 2'd0;
      count_r    <= 8'd0;
      ofs_r      <= 16'd0;
      kind_r     <= 8'd0;
      didx_r     <= 8'd0;
      ext_r      <= 8'd0;
      base_r     <= 32'd0;
      high_r     <= 32'd0;
      cur_addr_r <= 32'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      nib_held_r <= nib_held_nxt;
      nib_val_r  <= nib_val_nxt;
      fidx_r     <= fidx_nxt;
      count_r    <= count_nxt;
      ofs_r      <= ofs_nxt;
      kind_r     <= kind_nxt;
      didx_r     <= didx_nxt;
      ext_r      <= ext_nxt;
      base_r     <= base_nxt;
      high_r     <= high_nxt;
      cur_addr_r <= cur_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RST;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ihex_res_fifo.sv =====
`default_nettype none
module ihex_res_fifo #(
  parameter int unsigned RES_DEPTH = ihex_pkg::RES_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ihex_pkg::res_push_t push,
  output logic                     room2,
  output logic                     res_vld,
  input  wire logic                res_rdy,
  output ihex_pkg::res_t           res
);
  import ihex_pkg::*;

  localparam int unsigned PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RES_DEPTH - 1);

  res_t             q_r [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_p1, wr_p2;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_p1   = ptr_inc(wr_ptr_r);
  assign wr_p2   = ptr_inc(wr_p1);
  assign res_vld = (cnt_r != '0);
  assign pop     = res_vld && res_rdy;
  assign res     = q_r[rd_ptr_r];
  assign room2   = (cnt_r <= CNT_W'(RES_DEPTH - 2));

  always_comb begin
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case (push.n)
      2'd1:    wr_ptr_nxt = wr_p1;
      2'd2:    wr_ptr_nxt = wr_p2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    cnt_nxt = cnt_r + CNT_W'(push.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_p1] <= push.r1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/intel_hex_record_loader_unit.sv =====
// Intel HEX loader: one text character enters per clock and is parsed in the same cycle.
// Each character gives zero, one or two results (a byte write, and a load-done item when
// the last character of the file ends a load); results leave one per clock on out_tready
// from a RES_DEPTH-entry queue, and in_tready drops while fewer than two queue slots
// are free, so the sustained rate is one character per cycle with a ready output side.
// No checksum check; the capacity register must only be written while the loader is idle.
`default_nettype none
module intel_hex_record_loader_unit #(
  parameter int unsigned RES_DEPTH = ihex_pkg::RES_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_in
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // address, data_byte, length
  output logic             out_tuser,  // kind
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata   // capacity
);
  import ihex_pkg::*;

  res_push_t push;
  res_t      res;
  logic      room2;
  logic      step;

  assign in_tready = room2;
  assign step      = in_tvalid && in_tready;

  ihex_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .char_in      (in_tdata),
    .end_of_input (in_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push)
  );

  ihex_res_fifo #(
    .RES_DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room2   (room2),
    .res_vld (out_tvalid),
    .res_rdy (out_tready),
    .res     (res)
  );

  assign out_tdata = {res.length, res.data_byte, res.address};
  assign out_tuser = res.kind;

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |=> out_tvalid)
    else $error("pushed result not visible");

  a_two_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> step && in_tlast)
    else $error("two results without end of input");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DONE |-> out_tdata[39:0] == 40'd0)
    else $error("done item carries write fields");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_WRITE |-> out_tdata[71:40] == 32'd0)
    else $error("write item carries a length");

endmodule
`default_nettype wire

// ===== verif/tb_intel_hex_record_loader_unit.sv =====
`timescale 1ns / 1ps
module tb_intel_hex_record_loader_unit;
  import ihex_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 6;
  localparam int PHASE_CHARS = 165;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] BLANKS [5] = '{CHAR_SPACE, CHAR_TAB, 8'h0B, 8'h0C, CHAR_CR};
  localparam int IN_ODDS [PHASES] = '{6, 0, 3, 8, 4, 0};
  localparam int OUT_ODDS [PHASES] = '{5, 3, 0, 8, 4, 0};

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    int         n;
    res_t       r0;
    res_t       r1;
  } char_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // char_in
  logic        in_tlast = 1'b0; // end_of_input
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // address, data_byte, length
  logic        out_tuser;       // kind
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;  // capacity

  intel_hex_record_loader_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // loader state as the parser sees it
  logic [31:0] mem_size;
  phase_t      cur_phase;
  logic        digit_held;
  logic [3:0]  digit_hi;
  logic [1:0]  pair_no;
  logic [7:0]  rec_len;
  logic [15:0] rec_ofs;
  logic [7:0]  rec_code;
  logic [7:0]  byte_no;
  logic        ext_second;
  logic [7:0]  ext_hi;
  logic [31:0] seg_base;
  logic [31:0] top_end;

  res_t      load_ops[$];
  res_t      step_ops[$];
  char_row_t text_q[$];
  char_row_t dir_tab[$];

  int errors = 0;
  int writes_seen = 0;
  int loads_seen = 0;
  int chars_sent = 0;
  int files_sent = 0;
  int cap_writes = 0;
  int idle_cycles = 0;
  int in_gap_odds = 4;
  int out_gap_odds = 4;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic res_t byte_write(input logic [31:0] a, input logic [7:0] d);
    res_t r;
    r.kind = KIND_WRITE;
    r.address = a;
    r.data_byte = d;
    r.length = '0;
    return r;
  endfunction

  function automatic res_t load_done(input logic [31:0] len);
    res_t r;
    r.kind = KIND_DONE;
    r.address = '0;
    r.data_byte = '0;
    r.length = len;
    return r;
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h37;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h57;
    return 16;
  endfunction

  function automatic void clear_file();
    digit_held = 1'b0;
    digit_hi = '0;
    pair_no = FLD_COUNT;
    rec_len = '0;
    rec_ofs = '0;
    rec_code = '0;
    byte_no = '0;
    ext_second = 1'b0;
    ext_hi = '0;
    seg_base = '0;
    top_end = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [31:0] addr;
    logic [15:0] v;
    case (cur_phase)
      PH_HEADER: begin
        if (pair_no == FLD_TYPE) begin
          rec_code = b;
          if (b == REC_DATA) begin
            byte_no = '0;
            cur_phase = (rec_len == 8'd0) ? PH_SKIP : PH_DATA;
          end else if (b == REC_EOF) begin
            step_ops.push_back(load_done(top_end));
            clear_file();
            cur_phase = PH_FINISHED;
          end else if (b == REC_SEG || b == REC_LIN) begin
            ext_second = 1'b0;
            cur_phase = PH_EXT;
          end else begin
            cur_phase = PH_SKIP;
          end
        end else begin
          if (pair_no == FLD_COUNT) rec_len = b;
          else if (pair_no == FLD_OFS_HI) rec_ofs = {b, 8'h00};
          else rec_ofs[7:0] = b;
          pair_no = pair_no + 2'd1;
        end
      end
      PH_DATA: begin
        addr = seg_base + {16'h0, rec_ofs} + {24'h0, byte_no};
        if (addr < mem_size) step_ops.push_back(byte_write(addr, b));
        if (addr + 32'd1 > top_end) top_end = addr + 32'd1;
        byte_no = byte_no + 8'd1;
        if (byte_no == rec_len) cur_phase = PH_SKIP;
      end
      PH_EXT: begin
        if (!ext_second) begin
          ext_hi = b;
          ext_second = 1'b1;
        end else begin
          v = {ext_hi, b};
          seg_base = (rec_code == REC_SEG) ? {12'h0, v, 4'h0} : {v, 16'h0};
          cur_phase = PH_SKIP;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_hex_char(input logic [7:0] c, input logic last);
    int v;
    step_ops.delete();
    if (cur_phase == PH_FINISHED) begin
      // ignored until end of input
    end else if (c == CHAR_LF) begin
      cur_phase = PH_START;
      digit_held = 1'b0;
    end else if (cur_phase == PH_START) begin
      if (!(c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]})) begin
        if (c == CHAR_COLON) begin
          cur_phase = PH_HEADER;
          pair_no = FLD_COUNT;
          digit_held = 1'b0;
        end else begin
          cur_phase = PH_SKIP;
        end
      end
    end else if (cur_phase inside {PH_HEADER, PH_DATA, PH_EXT}) begin
      v = nibble_of(c);
      if (v > 15) begin
        cur_phase = PH_SKIP;
        digit_held = 1'b0;
      end else if (!digit_held) begin
        digit_held = 1'b1;
        digit_hi = v[3:0];
      end else begin
        digit_held = 1'b0;
        absorb_byte({digit_hi, v[3:0]});
      end
    end
    if (last) begin
      if (cur_phase != PH_FINISHED) step_ops.push_back(load_done(top_end));
      clear_file();
      cur_phase = PH_START;
    end
  endfunction

  function automatic char_row_t plain_row(input logic [7:0] c, input logic last);
    char_row_t r;
    r.ch = c;
    r.last = last;
    r.typed = 1'b0;
    r.n = 0;
    r.r0 = '0;
    r.r1 = '0;
    return r;
  endfunction

  function automatic char_row_t typed_row(input logic [7:0] c, input logic last, input int n,
                                          input res_t a, input res_t b);
    char_row_t r;
    r = plain_row(c, last);
    r.typed = 1'b1;
    r.n = n;
    r.r0 = a;
    r.r1 = b;
    return r;
  endfunction

  function automatic void check_field(input string fld, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, fld, want, got);
      errors++;
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] a;
    a = $urandom_range(0, 1) ? 8'h41 : 8'h61;
    return (v < 4'd10) ? 8'h30 + {4'h0, v} : a + {4'h0, v} - 8'd10;
  endfunction

  function automatic void put(input logic [7:0] c);
    text_q.push_back(plain_row(c, 1'b0));
  endfunction

  task automatic gen_line(input bit bare);
    logic [7:0]  rec[$];
    logic [15:0] v;
    logic [7:0]  c;
    int          pick;
    int          cnt;
    int          cut_at;
    int          i;
    bit          bad_mode;
    pick = bare ? 0 : $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put(BLANKS[$urandom_range(0, 4)]);
    if (pick >= 92) begin
      repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
    end else begin
      put(CHAR_COLON);
      case ($urandom_range(0, 2))
        0: v = 16'($urandom_range(0, 63));
        1: v = 16'($urandom_range(0, 65535));
        default: v = 16'($urandom_range(16'hFFF0, 16'hFFFF));
      endcase
      if (pick < 55) begin
        cnt = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
        if (!bare && $urandom_range(0, 9) == 0) rec.push_back(8'(cnt + $urandom_range(1, 4)));
        else rec.push_back(8'(cnt));
        rec.push_back(v[15:8]);
        rec.push_back(v[7:0]);
        rec.push_back(REC_DATA);
        repeat (cnt) rec.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 72) begin
        case ($urandom_range(0, 7))
          0, 1, 2: v = '0;
          3: v = 16'hFFFF;
          4, 5: v = 16'($urandom_range(1, 3));
          default: v = 16'($urandom_range(0, 65535));
        endcase
        rec.push_back(8'h02);
        rec.push_back(8'h00);
        rec.push_back(8'h00);
        rec.push_back($urandom_range(0, 1) ? REC_SEG : REC_LIN);
        rec.push_back(v[15:8]);
        rec.push_back(v[7:0]);
      end else if (pick < 79) begin
        rec.push_back(8'h00);
        rec.push_back(8'h00);
        rec.push_back(8'h00);
        rec.push_back(REC_EOF);
      end else begin
        cnt = $urandom_range(0, 4);
        rec.push_back(8'(cnt));
        rec.push_back(v[15:8]);
        rec.push_back(v[7:0]);
        do c = 8'($urandom_range(0, 255)); while (c inside {REC_DATA, REC_EOF, REC_SEG, REC_LIN});
        rec.push_back(c);
        repeat (cnt) rec.push_back(8'($urandom_range(0, 255)));
      end
      if (!bare && $urandom_range(0, 3) != 0) rec.push_back(8'($urandom_range(0, 255)));
      cut_at = (!bare && $urandom_range(0, 99) < 15) ? $urandom_range(0, 2 * rec.size() - 1) : -1;
      bad_mode = $urandom_range(0, 1);
      for (i = 0; i < 2 * rec.size(); i++) begin
        if (i == cut_at && !bad_mode) break;
        if (i == cut_at) begin
          do c = 8'($urandom_range(0, 255)); while (nibble_of(c) < 16 || c == CHAR_LF);
          put(c);
        end else begin
          put(hex_char((i % 2 == 0) ? rec[i / 2][7:4] : rec[i / 2][3:0]));
        end
      end
    end
    if (!bare) begin
      if ($urandom_range(0, 3) == 0) put(CHAR_CR);
      put(CHAR_LF);
    end
  endtask

  task automatic gen_file();
    char_row_t r;
    repeat ($urandom_range(1, 8)) gen_line(1'b0);
    if ($urandom_range(0, 3) == 0) gen_line(1'b1);
    r = text_q.pop_back();
    r.last = 1'b1;
    text_q.push_back(r);
    files_sent++;
  endtask

  task automatic push_char(input char_row_t row);
    if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = row.ch;
    in_tlast = row.last;
    do @(posedge clk); while (!in_tready);
    parse_hex_char(row.ch, row.last);
    if (row.typed) begin
      if (row.n > 0) load_ops.push_back(row.r0);
      if (row.n > 1) load_ops.push_back(row.r1);
    end else begin
      foreach (step_ops[i]) load_ops.push_back(step_ops[i]);
    end
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (load_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_capacity(input logic [31:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    mem_size = v;
    cap_writes++;
  endtask

  always @(negedge clk) begin
    if (out_gap_odds != 0 && $urandom_range(1, out_gap_odds) == 1) begin
      out_tready = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    out_tready = 1'b1;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (load_ops.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, got kind %0b tdata %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = load_ops.pop_front();
        check_field("kind", {31'h0, want.kind}, {31'h0, out_tuser});
        check_field("address", want.address, out_tdata[31:0]);
        check_field("data_byte", {24'h0, want.data_byte}, {24'h0, out_tdata[39:32]});
        check_field("length", want.length, out_tdata[71:40]);
        if (want.kind == KIND_DONE) loads_seen++;
        else writes_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int          p;
    string       s;
    logic [31:0] caps [PHASES];
    mem_size = CAPACITY_RST;
    cur_phase = PH_START;
    clear_file();
    caps[0] = CAPACITY_RST;
    caps[1] = '0;
    caps[2] = 32'hFFFF_FFFF;
    caps[3] = $urandom_range(1, 32'h0002_0000);
    caps[4] = $urandom();
    caps[5] = CAPACITY_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // non-colon line, one data byte, end record, then a trailing char with end of input
    dir_tab.push_back(typed_row(8'h00, 1'b0, 0, '0, '0));
    dir_tab.push_back(plain_row(CHAR_LF, 1'b0));
    s = " :01000000a";
    foreach (s[i]) dir_tab.push_back(plain_row(s[i], 1'b0));
    dir_tab.push_back(typed_row("b", 1'b0, 1, byte_write(32'h0, 8'hAB), '0));
    dir_tab.push_back(plain_row(CHAR_LF, 1'b0));
    s = ":0000000";
    foreach (s[i]) dir_tab.push_back(plain_row(s[i], 1'b0));
    dir_tab.push_back(typed_row("1", 1'b0, 1, load_done(32'd1), '0));
    dir_tab.push_back(typed_row(8'hFF, 1'b1, 0, '0, '0));
    foreach (dir_tab[i]) push_char(dir_tab[i]);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) set_capacity(caps[p]);
      in_gap_odds = IN_ODDS[p];
      out_gap_odds = OUT_ODDS[p];
      text_q.delete();
      while (text_q.size() < PHASE_CHARS) gen_file();
      foreach (text_q[i]) push_char(text_q[i]);
      wait_drained();
    end

    $display("sent %0d characters in %0d random files, capacity rewritten %0d times",
             chars_sent, files_sent, cap_writes);
    $display("checked %0d byte writes and %0d load-done items", writes_seen, loads_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ihex_pkg.sv
rtl/core/ihex_parser.sv
rtl/core/ihex_res_fifo.sv
rtl/core/intel_hex_record_loader_unit.sv
verif/tb_intel_hex_record_loader_unit.sv
